### rtl/core/plc_pkg.sv
`default_nettype none
package plc_pkg;

  localparam int KEY_LENGTH = 5;
  localparam int IDX_W      = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;

  typedef logic [BYTE_W-1:0]                 byte_t;
  typedef logic [KEY_LENGTH-1:0][BYTE_W-1:0] key_t;
  typedef logic [IDX_W-1:0]                  idx_t;
  typedef logic [CFG_IDX_W-1:0]              cfg_idx_t;
  typedef logic [1:0]                        motor_t;

  localparam cfg_idx_t CFG_OPEN_TICKS  = 2'd0;
  localparam cfg_idx_t CFG_HOLD_TICKS  = 2'd1;
  localparam cfg_idx_t CFG_ALARM_TICKS = 2'd2;

  localparam byte_t OPEN_TICKS_RST  = 8'd30;
  localparam byte_t HOLD_TICKS_RST  = 8'd7;
  localparam byte_t ALARM_TICKS_RST = 8'd116;

  localparam motor_t MOTOR_STOP = 2'd0;
  localparam motor_t MOTOR_CW   = 2'd1;
  localparam motor_t MOTOR_CCW  = 2'd2;

  localparam byte_t OPT_ALARM  = 8'h65;  // 'e'
  localparam byte_t OPT_REPLAY = 8'h72;  // 'r'
  localparam byte_t OPT_GATE   = 8'h67;  // 'g'
  localparam byte_t OPT_PWD    = 8'h70;  // 'p'

  localparam byte_t RSP_ZERO   = 8'h30;  // '0'
  localparam byte_t RSP_SAVED  = 8'h32;  // '2'
  localparam byte_t RSP_BAD    = 8'h35;  // '5'
  localparam byte_t RSP_GATE   = 8'h47;  // 'G'
  localparam byte_t RSP_ALARM  = 8'h6F;  // 'o'

endpackage
`default_nettype wire

### rtl/core/plc_in_if.sv
`default_nettype none
interface plc_in_if;
  logic                valid;
  logic                ready;
  logic                op;
  plc_pkg::byte_t      rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/plc_out_if.sv
`default_nettype none
interface plc_out_if;
  logic                valid;
  logic                ready;
  logic                tx_valid;
  plc_pkg::byte_t      tx_byte;
  plc_pkg::motor_t     motor_drive;
  logic                buzzer_active;

  modport source (output valid, output tx_valid, output tx_byte, output motor_drive,
                  output buzzer_active, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input motor_drive,
                  input buzzer_active, output ready);
endinterface
`default_nettype wire

### rtl/core/plc_cfg_if.sv
`default_nettype none
interface plc_cfg_if;
  logic                valid;
  logic                ready;
  plc_pkg::cfg_idx_t   index;
  plc_pkg::byte_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/password_lock_controller.sv
// An accepted input transaction passes through the input register, one pass of
// control logic and the output register. Throughput: one transaction per cycle
// unless the output stalls; the output register is freed in the cycle it is taken.
// Reset (rst_n low, synchronous): phase back to first password entry, counters,
// options, motor and buzzer cleared, tick registers back to 30/7/116.
`default_nettype none
module password_lock_controller (
  input  wire         clk,
  input  wire         rst_n,
  plc_in_if.sink      in_ch,
  plc_out_if.source   out_ch,
  plc_cfg_if.sink     cfg_ch
);

  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_SECOND = 3'd1;
  localparam logic [2:0] PH_OPTION = 3'd2;
  localparam logic [2:0] PH_VERIFY = 3'd3;
  localparam logic [2:0] PH_ALARM  = 3'd4;
  localparam logic [2:0] PH_OPEN   = 3'd5;
  localparam logic [2:0] PH_HOLD   = 3'd6;
  localparam logic [2:0] PH_CLOSE  = 3'd7;

  plc_pkg::byte_t  open_ticks_r, hold_ticks_r, alarm_ticks_r;

  logic            in_valid_r;
  logic            in_op_r;
  plc_pkg::byte_t  in_byte_r;

  logic [2:0]      phase_r, phase_nxt;
  plc_pkg::key_t   first_key_r, first_key_nxt;
  plc_pkg::key_t   second_key_r, second_key_nxt;
  plc_pkg::key_t   saved_key_r, saved_key_nxt;
  plc_pkg::idx_t   byte_index_r, byte_index_nxt;
  plc_pkg::byte_t  pending_option_r, pending_option_nxt;
  plc_pkg::byte_t  last_option_r, last_option_nxt;
  plc_pkg::byte_t  tick_count_r, tick_count_nxt;
  plc_pkg::motor_t motor_state_r, motor_state_nxt;
  logic            buzzer_state_r, buzzer_state_nxt;

  logic            out_valid_r;
  logic            tx_valid_r;
  plc_pkg::byte_t  tx_byte_r;
  plc_pkg::motor_t motor_drive_r;
  logic            buzzer_active_r;

  logic            adv;
  logic            send;
  plc_pkg::byte_t  reply;
  plc_pkg::byte_t  cnt_inc;
  plc_pkg::byte_t  opt;
  logic            last_byte;

  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign cfg_ch.ready = 1'b1;
  assign cnt_inc      = tick_count_r + 8'd1;
  assign last_byte    = (byte_index_r == plc_pkg::idx_t'(plc_pkg::KEY_LENGTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_ticks_r  <= plc_pkg::OPEN_TICKS_RST;
      hold_ticks_r  <= plc_pkg::HOLD_TICKS_RST;
      alarm_ticks_r <= plc_pkg::ALARM_TICKS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        plc_pkg::CFG_OPEN_TICKS:  open_ticks_r  <= cfg_ch.data;
        plc_pkg::CFG_HOLD_TICKS:  hold_ticks_r  <= cfg_ch.data;
        plc_pkg::CFG_ALARM_TICKS: alarm_ticks_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_op_r   <= in_ch.op;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  always_comb begin
    phase_nxt          = phase_r;
    first_key_nxt      = first_key_r;
    second_key_nxt     = second_key_r;
    saved_key_nxt      = saved_key_r;
    byte_index_nxt     = byte_index_r;
    pending_option_nxt = pending_option_r;
    last_option_nxt    = last_option_r;
    tick_count_nxt     = tick_count_r;
    motor_state_nxt    = motor_state_r;
    buzzer_state_nxt   = buzzer_state_r;
    send               = 1'b0;
    reply              = '0;
    opt                = (pending_option_r == plc_pkg::OPT_REPLAY) ? last_option_r
                                                                  : pending_option_r;
    if (in_op_r) begin
      unique case (phase_r)
        PH_ALARM: begin
          if (cnt_inc >= alarm_ticks_r) begin
            tick_count_nxt   = '0;
            buzzer_state_nxt = 1'b0;
            send             = 1'b1;
            reply            = plc_pkg::RSP_ALARM;
            phase_nxt        = PH_OPTION;
          end else begin
            tick_count_nxt = cnt_inc;
          end
        end
        PH_OPEN: begin
          if (cnt_inc >= open_ticks_r) begin
            tick_count_nxt  = '0;
            motor_state_nxt = plc_pkg::MOTOR_STOP;
            phase_nxt       = PH_HOLD;
          end else begin
            tick_count_nxt = cnt_inc;
          end
        end
        PH_HOLD: begin
          if (cnt_inc >= hold_ticks_r) begin
            tick_count_nxt  = '0;
            motor_state_nxt = plc_pkg::MOTOR_CCW;
            phase_nxt       = PH_CLOSE;
          end else begin
            tick_count_nxt = cnt_inc;
          end
        end
        PH_CLOSE: begin
          if (cnt_inc >= open_ticks_r) begin
            tick_count_nxt  = '0;
            motor_state_nxt = plc_pkg::MOTOR_STOP;
            phase_nxt       = PH_OPTION;
          end else begin
            tick_count_nxt = cnt_inc;
          end
        end
        default: ;
      endcase
    end else begin
      unique case (phase_r)
        PH_FIRST: begin
          first_key_nxt[byte_index_r] = in_byte_r;
          if (last_byte) begin
            byte_index_nxt = '0;
            phase_nxt      = PH_SECOND;
          end else begin
            byte_index_nxt = byte_index_r + plc_pkg::idx_t'(1);
          end
        end
        PH_SECOND: begin
          second_key_nxt[byte_index_r] = in_byte_r;
          if (last_byte) begin
            byte_index_nxt = '0;
            send           = 1'b1;
            if (first_key_r == second_key_nxt) begin
              saved_key_nxt = first_key_r;
              reply         = plc_pkg::RSP_SAVED;
              phase_nxt     = PH_OPTION;
            end else begin
              reply     = plc_pkg::RSP_ZERO;
              phase_nxt = PH_FIRST;
            end
          end else begin
            byte_index_nxt = byte_index_r + plc_pkg::idx_t'(1);
          end
        end
        PH_OPTION: begin
          if (in_byte_r == plc_pkg::OPT_ALARM) begin
            buzzer_state_nxt = 1'b1;
            tick_count_nxt   = '0;
            phase_nxt        = PH_ALARM;
          end else begin
            pending_option_nxt = in_byte_r;
            byte_index_nxt     = '0;
            phase_nxt          = PH_VERIFY;
          end
        end
        PH_VERIFY: begin
          first_key_nxt[byte_index_r] = in_byte_r;
          if (last_byte) begin
            byte_index_nxt = '0;
            phase_nxt      = PH_OPTION;
            if (first_key_nxt != saved_key_r) begin
              last_option_nxt = pending_option_r;
              send            = 1'b1;
              reply           = plc_pkg::RSP_BAD;
            end else if (opt == plc_pkg::OPT_GATE) begin
              last_option_nxt = opt;
              send            = 1'b1;
              reply           = plc_pkg::RSP_GATE;
              motor_state_nxt = plc_pkg::MOTOR_CW;
              tick_count_nxt  = '0;
              phase_nxt       = PH_OPEN;
            end else if (opt == plc_pkg::OPT_PWD) begin
              last_option_nxt = opt;
              send            = 1'b1;
              reply           = plc_pkg::RSP_ZERO;
              phase_nxt       = PH_FIRST;
            end
          end else begin
            byte_index_nxt = byte_index_r + plc_pkg::idx_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_FIRST;
      byte_index_r     <= '0;
      pending_option_r <= '0;
      last_option_r    <= '0;
      tick_count_r     <= '0;
      motor_state_r    <= plc_pkg::MOTOR_STOP;
      buzzer_state_r   <= 1'b0;
    end else if (adv) begin
      phase_r          <= phase_nxt;
      byte_index_r     <= byte_index_nxt;
      pending_option_r <= pending_option_nxt;
      last_option_r    <= last_option_nxt;
      tick_count_r     <= tick_count_nxt;
      motor_state_r    <= motor_state_nxt;
      buzzer_state_r   <= buzzer_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_key_r  <= first_key_nxt;
      second_key_r <= second_key_nxt;
      saved_key_r  <= saved_key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_valid_r      <= send;
      tx_byte_r       <= reply;
      motor_drive_r   <= motor_state_nxt;
      buzzer_active_r <= buzzer_state_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tx_valid      = tx_valid_r;
  assign out_ch.tx_byte       = tx_byte_r;
  assign out_ch.motor_drive   = motor_drive_r;
  assign out_ch.buzzer_active = buzzer_active_r;

endmodule
`default_nettype wire

### rtl/core/plc_checker.sv
`default_nettype none
module plc_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire                  tx_valid,
  input wire plc_pkg::byte_t  tx_byte,
  input wire plc_pkg::motor_t motor_drive,
  input wire                  buzzer_active
);

  // stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_valid) && $stable(tx_byte)
      && $stable(motor_drive) && $stable(buzzer_active))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_tx_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!tx_valid && tx_byte == '0)
      || (tx_valid && (tx_byte == plc_pkg::RSP_ZERO || tx_byte == plc_pkg::RSP_SAVED
      || tx_byte == plc_pkg::RSP_BAD || tx_byte == plc_pkg::RSP_GATE
      || tx_byte == plc_pkg::RSP_ALARM)))
    else $error("bad reply byte");

  a_motor_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> motor_drive != 2'd3)
    else $error("bad motor code");

  a_buzz_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && buzzer_active |-> motor_drive == plc_pkg::MOTOR_STOP)
    else $error("buzzer and motor active together");

endmodule

bind password_lock_controller plc_checker u_plc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .tx_valid      (out_ch.tx_valid),
  .tx_byte       (out_ch.tx_byte),
  .motor_drive   (out_ch.motor_drive),
  .buzzer_active (out_ch.buzzer_active)
);
`default_nettype wire

### tb/sv/password_lock_controller_test.sv
`timescale 1ns / 100ps
module password_lock_controller_test;
  import plc_pkg::*;

  localparam logic     OP_BYTE         = 1'b0;
  localparam logic     OP_TICK         = 1'b1;
  localparam cfg_idx_t CFG_SPARE       = 2'd3;
  localparam byte_t    OPT_UNKNOWN     = 8'h7A;
  localparam int       SETTLE_CYCLES   = 8;
  localparam int       IDLE_LIMIT      = 4000;
  localparam int       HOLD_OFF_CYCLES = 300;
  localparam int       HOLD_OFF_AFTER  = 250;
  localparam int       MAX_REPORTS     = 20;

  typedef enum logic [3:0] {
    ST_KEY1, ST_KEY2, ST_OPTION, ST_VERIFY, ST_ALARM, ST_OPEN, ST_HOLD, ST_CLOSE
  } lock_phase_e;

  typedef struct packed {
    logic   tx_valid;
    byte_t  tx_byte;
    motor_t motor_drive;
    logic   buzzer_active;
  } lock_reply_t;

  typedef struct packed {
    logic  op;
    byte_t data;
    logic  counted;
  } lock_item_t;

  class lock_replies;
    byte_t       open_len;
    byte_t       hold_len;
    byte_t       alarm_len;
    lock_phase_e phase;
    key_t        key_a;
    key_t        key_b;
    key_t        saved_key;
    int          key_pos;
    byte_t       opt_pending;
    byte_t       opt_last;
    byte_t       ticks;
    motor_t      motor;
    logic        buzzer;
    lock_reply_t replies_due[$];
    int unsigned errors;

    function new();
      open_len    = OPEN_TICKS_RST;
      hold_len    = HOLD_TICKS_RST;
      alarm_len   = ALARM_TICKS_RST;
      phase       = ST_KEY1;
      key_a       = '0;
      key_b       = '0;
      saved_key   = '0;
      key_pos     = 0;
      opt_pending = '0;
      opt_last    = '0;
      ticks       = '0;
      motor       = MOTOR_STOP;
      buzzer      = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, byte_t val);
      case (idx)
        CFG_OPEN_TICKS:  open_len  = val;
        CFG_HOLD_TICKS:  hold_len  = val;
        CFG_ALARM_TICKS: alarm_len = val;
        default: ;
      endcase
    endfunction

    // A zero limit ends the count on the first tick.
    function bit tick_done(byte_t limit);
      ticks = ticks + 8'd1;
      if (ticks >= limit) begin
        ticks = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_item(logic op, byte_t b);
      lock_reply_t r;
      byte_t       chosen;
      r = '0;
      if (op == OP_TICK) begin
        case (phase)
          ST_ALARM: if (tick_done(alarm_len)) begin
            buzzer     = 1'b0;
            r.tx_valid = 1'b1;
            r.tx_byte  = RSP_ALARM;
            phase      = ST_OPTION;
          end
          ST_OPEN: if (tick_done(open_len)) begin
            motor = MOTOR_STOP;
            phase = ST_HOLD;
          end
          ST_HOLD: if (tick_done(hold_len)) begin
            motor = MOTOR_CCW;
            phase = ST_CLOSE;
          end
          ST_CLOSE: if (tick_done(open_len)) begin
            motor = MOTOR_STOP;
            phase = ST_OPTION;
          end
          default: ;
        endcase
      end else begin
        case (phase)
          ST_KEY1: begin
            key_a[key_pos] = b;
            if (key_pos == KEY_LENGTH - 1) begin
              key_pos = 0;
              phase   = ST_KEY2;
            end else begin
              key_pos++;
            end
          end
          ST_KEY2: begin
            key_b[key_pos] = b;
            if (key_pos == KEY_LENGTH - 1) begin
              key_pos    = 0;
              r.tx_valid = 1'b1;
              if (key_a == key_b) begin
                saved_key = key_a;
                r.tx_byte = RSP_SAVED;
                phase     = ST_OPTION;
              end else begin
                r.tx_byte = RSP_ZERO;
                phase     = ST_KEY1;
              end
            end else begin
              key_pos++;
            end
          end
          ST_OPTION: begin
            if (b == OPT_ALARM) begin
              buzzer = 1'b1;
              ticks  = '0;
              phase  = ST_ALARM;
            end else begin
              opt_pending = b;
              key_pos     = 0;
              phase       = ST_VERIFY;
            end
          end
          ST_VERIFY: begin
            key_a[key_pos] = b;
            if (key_pos == KEY_LENGTH - 1) begin
              key_pos = 0;
              phase   = ST_OPTION;
              if (key_a != saved_key) begin
                opt_last   = opt_pending;
                r.tx_valid = 1'b1;
                r.tx_byte  = RSP_BAD;
              end else begin
                chosen = (opt_pending == OPT_REPLAY) ? opt_last : opt_pending;
                if (chosen == OPT_GATE) begin
                  opt_last   = chosen;
                  r.tx_valid = 1'b1;
                  r.tx_byte  = RSP_GATE;
                  motor      = MOTOR_CW;
                  ticks      = '0;
                  phase      = ST_OPEN;
                end else if (chosen == OPT_PWD) begin
                  opt_last   = chosen;
                  r.tx_valid = 1'b1;
                  r.tx_byte  = RSP_ZERO;
                  phase      = ST_KEY1;
                end
              end
            end else begin
              key_pos++;
            end
          end
          default: ;
        endcase
      end
      r.motor_drive   = motor;
      r.buzzer_active = buzzer;
      replies_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
    endtask

    task compare_reply(lock_reply_t got);
      lock_reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected transaction %p", got));
        return;
      end
      want = replies_due.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report($sformatf("tx_valid %b, want %b", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
      if (got.motor_drive !== want.motor_drive)
        report($sformatf("motor_drive %0d, want %0d", got.motor_drive, want.motor_drive));
      if (got.buzzer_active !== want.buzzer_active)
        report($sformatf("buzzer_active %b, want %b", got.buzzer_active,
                         want.buzzer_active));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  plc_in_if  in_ch ();
  plc_out_if out_ch ();
  plc_cfg_if cfg_ch ();

  password_lock_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lock_replies  replies = new();
  lock_item_t   plan_q[$];
  int unsigned  items_counted = 0;
  int unsigned  accepted_in   = 0;
  int unsigned  burst_left    = 0;
  int unsigned  idle_cycles   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_item(logic op, byte_t data, logic counted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.rx_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    replies.take_item(op, data);
    accepted_in++;
    if (counted) items_counted++;
  endtask

  task automatic write_reg(cfg_idx_t idx, byte_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    replies.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (replies.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ticks(byte_t open_len, byte_t hold_len, byte_t alarm_len);
    wait_idle();
    write_reg(CFG_OPEN_TICKS, open_len);
    write_reg(CFG_HOLD_TICKS, hold_len);
    write_reg(CFG_ALARM_TICKS, alarm_len);
  endtask

  function automatic void queue_item(logic op, byte_t data, logic counted);
    plan_q.push_back('{op: op, data: data, counted: counted});
  endfunction

  function automatic void queue_key(key_t k);
    for (int i = 0; i < KEY_LENGTH; i++) queue_item(OP_BYTE, k[i], 1'b1);
  endfunction

  function automatic key_t random_key();
    key_t k;
    for (int i = 0; i < KEY_LENGTH; i++) k[i] = byte_t'($urandom_range(0, 255));
    return k;
  endfunction

  function automatic key_t spoil_key(key_t k);
    k[$urandom_range(0, KEY_LENGTH - 1)] ^= byte_t'($urandom_range(1, 255));
    return k;
  endfunction

  // Next stretch of stimulus, chosen from where the lock currently stands.
  function automatic void plan_next();
    key_t        k;
    byte_t       opt;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    case (replies.phase)
      ST_KEY1: begin
        if (pick < 8) begin
          queue_item(OP_TICK, byte_t'($urandom_range(0, 255)), 1'b0);
        end else if (replies.key_pos != 0 || pick < 14) begin
          queue_item(OP_BYTE, byte_t'($urandom_range(0, 255)), 1'b1);
        end else begin
          k = random_key();
          queue_key(k);
          queue_key((pick < 75) ? k : spoil_key(k));
        end
      end
      ST_KEY2, ST_VERIFY: begin
        if (pick < 8) queue_item(OP_TICK, byte_t'($urandom_range(0, 255)), 1'b0);
        else queue_item(OP_BYTE, byte_t'($urandom_range(0, 255)), 1'b1);
      end
      ST_OPTION: begin
        if (pick < 8) begin
          queue_item(OP_TICK, byte_t'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 22) begin
          queue_item(OP_BYTE, OPT_ALARM, 1'b1);
        end else begin
          if (pick < 50) opt = OPT_GATE;
          else if (pick < 64) opt = OPT_REPLAY;
          else if (pick < 72) opt = OPT_PWD;
          else if (pick < 80) opt = OPT_UNKNOWN;
          else begin
            opt = byte_t'($urandom_range(0, 255));
            if (opt == OPT_ALARM) opt = OPT_UNKNOWN;
          end
          queue_item(OP_BYTE, opt, 1'b1);
          queue_key(($urandom_range(0, 4) == 0) ? spoil_key(replies.saved_key)
                                                : replies.saved_key);
        end
      end
      default: begin
        if (pick < 10) queue_item(OP_BYTE, byte_t'($urandom_range(0, 255)), 1'b0);
        else queue_item(OP_TICK, byte_t'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endfunction

  task automatic run_random(int unsigned budget);
    int unsigned stop_at;
    lock_item_t  it;
    stop_at = items_counted + budget;
    plan_q.delete();
    while (items_counted < stop_at) begin
      if (plan_q.size() == 0) plan_next();
      it = plan_q.pop_front();
      send_item(it.op, it.data, it.counted);
    end
  endtask

  task automatic run_directed();
    key_t good_key;
    key_t bad_key;
    good_key = {8'h01, 8'h55, 8'hAA, 8'h00, 8'hFF};
    bad_key  = {8'h80, 8'hAA, 8'h55, 8'hFF, 8'h00};
    plan_q.delete();
    queue_item(OP_TICK, 8'hFF, 1'b1);
    queue_key(bad_key);
    queue_key(bad_key ^ {8'h01, {(KEY_LENGTH-1)*8{1'b0}}});
    queue_key(good_key);
    queue_key(good_key);
    queue_item(OP_BYTE, OPT_UNKNOWN, 1'b1);
    queue_key(good_key);
    while (plan_q.size() != 0) begin
      send_item(plan_q[0].op, plan_q[0].data, plan_q[0].counted);
      void'(plan_q.pop_front());
    end
  endtask

  // receiver: changing stall patterns, one long hold-off once traffic is going
  initial begin
    int unsigned mode;
    int unsigned run;
    int unsigned stall_left;
    bit          held;
    mode         = 0;
    run          = 0;
    stall_left   = 0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(4, 40);
      end
      run--;
      if (!held && accepted_in >= HOLD_OFF_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ($urandom_range(0, 7) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      replies.compare_reply(lock_reply_t'{out_ch.tx_valid, out_ch.tx_byte,
                                          out_ch.motor_drive, out_ch.buzzer_active});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("password_lock_controller_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_BYTE;
    in_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_OPEN_TICKS;
    cfg_ch.data   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(60);

    set_ticks(8'd1, 8'd1, 8'd1);
    run_random(120);

    set_ticks(8'd0, 8'd0, 8'd0);
    write_reg(CFG_SPARE, 8'hFF);
    run_random(100);

    set_ticks(byte_t'($urandom_range(2, 12)), byte_t'($urandom_range(2, 12)),
              byte_t'($urandom_range(2, 12)));
    run_random(200);

    set_ticks(8'd255, 8'd255, 8'd255);
    run_random(250);

    set_ticks(byte_t'($urandom_range(1, 20)), byte_t'($urandom_range(1, 20)),
              byte_t'($urandom_range(1, 20)));
    run_random(100);

    wait_idle();
    if (replies.errors == 0) begin
      $display("password_lock_controller_test: done, clean");
    end else begin
      $display("password_lock_controller_test: done, errors");
    end
    $finish;
  end

endmodule

### password_lock_controller.f
rtl/core/plc_pkg.sv
rtl/core/plc_in_if.sv
rtl/core/plc_out_if.sv
rtl/core/plc_cfg_if.sv
rtl/core/password_lock_controller.sv
rtl/core/plc_checker.sv
tb/sv/password_lock_controller_test.sv
